// File: design/vpn_pkg.sv
// shared types, constants and helper functions for the voss pink noise generator
// no dependencies; imported by vpn_ctrl, vpn_dp and voss_pink_noise_generator
package vpn_pkg;

  // twister geometry and constants
  localparam int TW_WORDS = 624;
  localparam int TW_AW = 10;
  localparam int TW_SHIFT = 397;
  localparam logic [31:0] TW_MATRIX = 32'h9908B0DF;
  localparam logic [31:0] TW_INIT_MULT = 32'd1812433253;
  localparam logic [31:0] TW_DEFAULT_SEED = 32'd5489;

  // default parameter values
  localparam int RANGE_BITS_DEF = 16;

  // field and register widths
  localparam int RANGE_W = 17;
  localparam int START_W = 16;
  localparam int K_W = 16;
  localparam int OUT_W = 18;
  localparam int SUM_W = 22;
  localparam int DK_W = 20;
  localparam int SEED_W = 32;
  localparam int TDATA_IN_W = 32;
  localparam int TDATA_OUT_W = 24;

  // register indexes and reset values
  localparam logic CFG_RANGE = 1'b0;
  localparam logic CFG_START = 1'b1;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 17'd128;
  localparam logic [START_W-1:0] START_RESET = 16'd0;

  // input kinds
  localparam logic KIND_NOISE = 1'b0;
  localparam logic KIND_SEED = 1'b1;

  // saturation bounds
  localparam logic signed [SUM_W-1:0] SUM_MAX = 22'sd524284;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -22'sd524288;
  localparam logic signed [SUM_W-1:0] OUT_MAX = 22'sd131071;
  localparam logic signed [SUM_W-1:0] OUT_MIN = -22'sd131072;

  // controller states
  typedef enum logic [3:0] {
    ST_BOOT, ST_SEED_INIT, ST_SEED_MUL, ST_SEED_WR, ST_IDLE, ST_STEP_CHK, ST_DIV,
    ST_DIG, ST_TW_LOAD, ST_TW_RD, ST_TW_WR, ST_DRAW_RD, ST_DRAW_USE, ST_STEP_ACC,
    ST_FINISH, ST_SEED_ACK
  } vpn_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic boot;
    logic take_seed;
    logic seed_init;
    logic seed_mul;
    logic seed_wr;
    logic noise_init;
    logic div_start;
    logic div_step;
    logic dig;
    logic tw_load;
    logic tw_rd;
    logic tw_wr;
    logic draw_rd;
    logic draw_use;
    logic step_acc;
    logic out_noise;
    logic out_seed;
  } vpn_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ctr_last;
    logic k_zero;
    logic step_max;
    logic div_done;
    logic tw_empty;
    logic out_free;
  } vpn_stat_t;

  // mt19937 output tempering
  function automatic logic [31:0] vpn_temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: design/vpn_ctrl.sv
// controller state machine for the voss pink noise generator
// depends on vpn_pkg; drives vpn_dp through command and status structs
module vpn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               kind,
  output logic               s_tready,
  input  vpn_pkg::vpn_stat_t st,
  output vpn_pkg::vpn_cmd_t  cmd
);
  import vpn_pkg::*;

  vpn_state_t state, state_next;
  logic ack, ack_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BOOT;
      ack <= 1'b0;
    end else begin
      state <= state_next;
      ack <= ack_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    ack_next = ack;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_BOOT: begin
        cmd.boot = 1'b1;
        state_next = ST_SEED_INIT;
      end
      ST_SEED_INIT: begin
        cmd.seed_init = 1'b1;
        state_next = ST_SEED_MUL;
      end
      ST_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_next = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        if (st.ctr_last) state_next = ack ? ST_SEED_ACK : ST_IDLE;
        else state_next = ST_SEED_MUL;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (kind == KIND_SEED) begin
            cmd.take_seed = 1'b1;
            ack_next = 1'b1;
            state_next = ST_SEED_INIT;
          end else begin
            cmd.noise_init = 1'b1;
            state_next = ST_STEP_CHK;
          end
        end
      end
      ST_STEP_CHK: begin
        if (st.k_zero || st.step_max) state_next = ST_FINISH;
        else begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_next = ST_DIG;
      end
      ST_DIG: begin
        cmd.dig = 1'b1;
        state_next = st.tw_empty ? ST_TW_LOAD : ST_DRAW_RD;
      end
      ST_TW_LOAD: begin
        cmd.tw_load = 1'b1;
        state_next = ST_TW_RD;
      end
      ST_TW_RD: begin
        cmd.tw_rd = 1'b1;
        state_next = ST_TW_WR;
      end
      ST_TW_WR: begin
        cmd.tw_wr = 1'b1;
        state_next = st.ctr_last ? ST_DRAW_RD : ST_TW_RD;
      end
      ST_DRAW_RD: begin
        cmd.draw_rd = 1'b1;
        state_next = ST_DRAW_USE;
      end
      ST_DRAW_USE: begin
        cmd.draw_use = 1'b1;
        state_next = ST_STEP_ACC;
      end
      ST_STEP_ACC: begin
        cmd.step_acc = 1'b1;
        state_next = ST_STEP_CHK;
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.out_noise = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SEED_ACK: begin
        if (st.out_free) begin
          cmd.out_seed = 1'b1;
          ack_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_BOOT;
    endcase
  end

  // result loads only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_noise || cmd.out_seed) |-> st.out_free)
    else $error("result loaded into a full output register");

  // a division start is followed by division steps
  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> cmd.div_step)
    else $error("division start not followed by a step");

  // a reseed transaction starts the seeding pass
  a_reseed: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && kind == KIND_SEED) |=> state == ST_SEED_INIT && ack)
    else $error("reseed transaction did not start seeding");

  // a draw never happens on an exhausted twister
  a_draw: assert property (@(posedge clk) disable iff (rst)
    cmd.draw_rd |-> !st.tw_empty)
    else $error("draw from exhausted twister state");

endmodule

// File: design/vpn_dp.sv
// datapath for the voss pink noise generator: twister memory, divider,
// step accumulator, configuration and output registers; depends on vpn_pkg
module vpn_dp #(
  parameter int RANGE_BITS = vpn_pkg::RANGE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  vpn_pkg::vpn_cmd_t                  cmd,
  output vpn_pkg::vpn_stat_t                 st,
  input  logic [vpn_pkg::TDATA_IN_W-1:0]     s_tdata,
  input  logic                               cfg_wen,
  input  logic                               cfg_index,
  input  logic [vpn_pkg::RANGE_W-1:0]        cfg_data,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [vpn_pkg::TDATA_OUT_W-1:0]    m_tdata,
  output logic                               m_tuser
);
  import vpn_pkg::*;

  localparam int SW = $clog2(RANGE_BITS + 1);
  localparam int DIV_W = OUT_W;
  localparam int DCW = $clog2(DIV_W);

  // configuration and persistent state
  logic [RANGE_W-1:0] range_size;
  logic [START_W-1:0] start_level;
  logic started;
  logic signed [OUT_W-1:0] prev;
  logic [TW_AW-1:0] tw_index;

  // twister memory and its ports
  logic [31:0] mem [TW_WORDS];
  logic [31:0] rd_a, rd_b, cur, p, prod, wr_data;
  logic [TW_AW-1:0] ctr, addr_a, addr_b, wr_addr, ctr_p1;
  logic [TW_AW:0] ctr_sh;
  logic wr_en;

  // noise working registers
  logic signed [OUT_W-1:0] last;
  logic signed [SUM_W-1:0] sum;
  logic [K_W-1:0] k;
  logic [SW-1:0] step;
  logic [K_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic neg;
  logic [DCW-1:0] dcnt;
  logic signed [DK_W-1:0] dk;
  logic [48:0] uprod;

  // combinational helpers
  logic [K_W:0] rem_sh;
  logic ge;
  logic signed [DIV_W:0] digit;
  logic signed [DIV_W+K_W+1:0] dk_full;
  logic [31:0] v, tw_new, seed_next;
  logic flip;
  logic signed [SUM_W-1:0] k_s, dk_s, term, sum_add, sum_sat, out_sat;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      range_size <= RANGE_RESET;
      start_level <= START_RESET;
    end else if (cfg_wen) begin
      if (cfg_index == CFG_RANGE) range_size <= cfg_data;
      else start_level <= cfg_data[START_W-1:0];
    end
  end

  // twister addresses
  assign ctr_p1 = (ctr == TW_AW'(TW_WORDS - 1)) ? '0 : ctr + 1'b1;
  assign ctr_sh = {1'b0, ctr} + (TW_AW + 1)'(TW_SHIFT);
  assign addr_b = (ctr_sh >= (TW_AW + 1)'(TW_WORDS)) ?
                  TW_AW'(ctr_sh - (TW_AW + 1)'(TW_WORDS)) : ctr_sh[TW_AW-1:0];
  always_comb begin
    if (cmd.tw_load) addr_a = '0;
    else if (cmd.tw_rd || cmd.tw_wr) addr_a = ctr_p1;
    else addr_a = tw_index;
  end

  // twist and seeding word generation
  assign v = {cur[31], rd_a[30:0]};
  assign tw_new = rd_b ^ (v >> 1) ^ (v[0] ? TW_MATRIX : 32'd0);
  assign seed_next = prod + {22'd0, ctr};
  always_comb begin
    wr_en = 1'b0;
    wr_addr = ctr;
    wr_data = tw_new;
    if (cmd.seed_init) begin
      wr_en = 1'b1;
      wr_addr = '0;
      wr_data = p;
    end else if (cmd.seed_wr) begin
      wr_en = 1'b1;
      wr_data = seed_next;
    end else if (cmd.tw_wr) begin
      wr_en = 1'b1;
    end
  end

  // twister memory, registered reads
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // seeding and twist sequencing registers
  always_ff @(posedge clk) begin
    if (cmd.boot) p <= TW_DEFAULT_SEED;
    if (cmd.take_seed) p <= s_tdata[SEED_W-1:0];
    if (cmd.seed_init) ctr <= TW_AW'(1);
    if (cmd.seed_mul) prod <= TW_INIT_MULT * (p ^ (p >> 30));
    if (cmd.seed_wr) begin
      p <= seed_next;
      ctr <= ctr + 1'b1;
    end
    if (cmd.tw_load) ctr <= '0;
    if (cmd.tw_rd) cur <= rd_a;
    if (cmd.tw_wr) ctr <= ctr + 1'b1;
  end

  // draw index
  always_ff @(posedge clk) begin
    if (rst) tw_index <= TW_AW'(TW_WORDS);
    else if (cmd.seed_wr && st.ctr_last) tw_index <= TW_AW'(TW_WORDS);
    else if (cmd.tw_wr && st.ctr_last) tw_index <= '0;
    else if (cmd.draw_use) tw_index <= tw_index + 1'b1;
  end

  // divider step and digit
  assign rem_sh = {rem, quo[DIV_W-1]};
  assign ge = rem_sh >= {1'b0, k};
  assign digit = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign dk_full = digit * $signed({1'b0, k});

  // flip decision and accumulation
  assign flip = (uprod[48:32] >> step) == '0;
  assign k_s = $signed({{(SUM_W-K_W){1'b0}}, k});
  assign dk_s = {{(SUM_W-DK_W){dk[DK_W-1]}}, dk};
  assign term = flip ? k_s - dk_s : dk_s;
  assign sum_add = sum + term;
  assign sum_sat = (sum_add > SUM_MAX) ? SUM_MAX : (sum_add < SUM_MIN) ? SUM_MIN : sum_add;
  assign out_sat = (sum > OUT_MAX) ? OUT_MAX : (sum < OUT_MIN) ? OUT_MIN : sum;

  // noise working registers
  always_ff @(posedge clk) begin
    if (cmd.noise_init) begin
      last <= started ? prev : $signed({2'b00, start_level});
      sum <= '0;
      k <= range_size[RANGE_W-1:1];
      step <= '0;
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= last[OUT_W-1] ? DIV_W'(-last) : DIV_W'(last);
      neg <= last[OUT_W-1];
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? K_W'(rem_sh - {1'b0, k}) : rem_sh[K_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.dig) begin
      dk <= dk_full[DK_W-1:0];
      if (digit == (DIV_W + 1)'(1)) last <= last - $signed({2'b00, k});
    end
    if (cmd.draw_use) uprod <= vpn_temper(rd_a) * range_size;
    if (cmd.step_acc) begin
      sum <= sum_sat;
      k <= k >> 1;
      step <= step + 1'b1;
    end
  end

  // result history
  always_ff @(posedge clk) begin
    if (rst) started <= 1'b0;
    else if (cmd.out_noise) started <= 1'b1;
    if (cmd.out_noise) prev <= out_sat[OUT_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_noise || cmd.out_seed) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (cmd.out_noise) begin
      m_tdata <= {{(TDATA_OUT_W-OUT_W){1'b0}}, out_sat[OUT_W-1:0]};
      m_tuser <= 1'b0;
    end else if (cmd.out_seed) begin
      m_tdata <= '0;
      m_tuser <= 1'b1;
    end
  end

  // status
  assign st.ctr_last = ctr == TW_AW'(TW_WORDS - 1);
  assign st.k_zero = k == '0;
  assign st.step_max = step == SW'(RANGE_BITS);
  assign st.div_done = dcnt == DCW'(DIV_W - 1);
  assign st.tw_empty = tw_index == TW_AW'(TW_WORDS);
  assign st.out_free = !m_tvalid || m_tready;

endmodule

// File: design/voss_pink_noise_generator.sv
// top level of the voss pink noise generator, mt19937 driven
// depends on vpn_pkg, vpn_ctrl and vpn_dp
//
//  channel   direction  signals                        contents
//  s_        in         tvalid tready tdata tuser      seed / kind
//  m_        out        tvalid tready tdata tuser      noise_value / was_seed
//  cfg_      in         wen index data                 range_size, start level
//
// each bit weight of a noise item runs a check, a radix-2 divider, digit, draw and
// accumulate, up to RANGE_BITS weights; every 624th draw adds a twist pass
// through the single two-read state memory
// reset and every reseed run a seeding pass, no input taken meanwhile
// one item at a time; a finished result waits in the output register and
// stalls the block only when the next result is ready
module voss_pink_noise_generator #(
  parameter int RANGE_BITS = vpn_pkg::RANGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [vpn_pkg::TDATA_IN_W-1:0]   s_tdata,   // [31:0] seed
  input  logic                             s_tuser,   // [0] kind
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [vpn_pkg::TDATA_OUT_W-1:0]  m_tdata,   // [17:0] noise_value, zero fill
  output logic                             m_tuser,   // [0] was_seed
  input  logic                             cfg_wen,
  input  logic                             cfg_index,
  input  logic [vpn_pkg::RANGE_W-1:0]      cfg_data
);
  import vpn_pkg::*;

  vpn_cmd_t cmd;
  vpn_stat_t st;

  // sequencing
  vpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // storage and arithmetic
  vpn_dp #(.RANGE_BITS(RANGE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
